// ===== sv/stt_pkg.sv =====
package stt_pkg;

	localparam int LINE_BITS_DEF = 16;
	localparam int LINE_OUT_W    = 16;
	localparam int EV_SLOTS      = 3;
	localparam int CNT_W         = $clog2(EV_SLOTS + 1);
	localparam int QUEUE_DEPTH   = 4;
	localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_NUM,
		MODE_STR
	} mode_t;

	localparam logic [1:0] EV_CHAR = 2'd0;
	localparam logic [1:0] EV_DONE = 2'd1;
	localparam logic [1:0] EV_EOF  = 2'd2;

	localparam logic [4:0] CLS_UNKNOWN = 5'd0;
	localparam logic [4:0] CLS_IDENT   = 5'd1;
	localparam logic [4:0] CLS_INT     = 5'd2;
	localparam logic [4:0] CLS_FLOAT   = 5'd3;
	localparam logic [4:0] CLS_STRING  = 5'd4;
	localparam logic [4:0] CLS_KW_BASE = 5'd5;
	localparam logic [4:0] CLS_OP_BASE = 5'd11;
	localparam logic [4:0] CLS_EOF     = 5'd25;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_UNKNOWN = 2'd1;
	localparam logic [1:0] ERR_NL      = 2'd2;

	typedef struct packed {
		logic [1:0]            kind;
		logic [4:0]            cls;
		logic [7:0]            chr;
		logic [LINE_OUT_W-1:0] line;
		logic [1:0]            err;
	} event_t;

	typedef struct packed {
		logic [CNT_W-1:0]            cnt;
		event_t [EV_SLOTS-1:0]       ev;
	} bundle_t;

endpackage

// ===== sv/source_text_tokenizer_top.sv =====
// channel | signals                                   | accepted when
// in      | in_valid, in_ready, text_byte, final_byte  | in_valid & in_ready
// out     | out_valid, out_ready, event_kind,          | out_valid & out_ready
//         | token_class, char_value, line_count,       |
//         | error_code, run_last                       |
//
// One byte accepted per cycle while the four-entry event queue has room.
// Each byte gives zero to three events; the back end sends one event per
// cycle from its output register while out_ready is high, taking a byte's events in turn.
// Bytes giving no event never enter the queue.
// Reset clears lexer state and sets the line number to one; no clearing pass.
// in_ready drops only when the queue is full; output stalls fill the queue.
module source_text_tokenizer_top
	import stt_pkg::*;
#(
	parameter int LINE_BITS = LINE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            text_byte,
	input  logic                  final_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            event_kind,
	output logic [4:0]            token_class,
	output logic [7:0]            char_value,
	output logic [LINE_OUT_W-1:0] line_count,
	output logic [1:0]            error_code,
	output logic                  run_last
);

	logic    space, wr_en, head_valid, pop;
	bundle_t wr_data, head;

	stt_front #(
		.LINE_BITS(LINE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.text_byte (text_byte),
		.final_byte(final_byte),
		.space     (space),
		.wr_en     (wr_en),
		.wr_data   (wr_data)
	);

	stt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_data   (wr_data),
		.space     (space),
		.rd_en     (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	stt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.event_kind (event_kind),
		.token_class(token_class),
		.char_value (char_value),
		.line_count (line_count),
		.error_code (error_code),
		.run_last   (run_last)
	);

	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == EV_EOF |-> run_last && token_class == CLS_EOF)
		else $error("eof event not last or wrong class");

	a_char_cls: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == EV_CHAR |->
		token_class != CLS_UNKNOWN && token_class <= CLS_STRING && error_code != ERR_UNKNOWN)
		else $error("token character with bad class");

	a_nl_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code == ERR_NL |-> token_class == CLS_STRING)
		else $error("newline error outside string");

	a_full_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("queue full with idle output");

endmodule

// ===== sv/stt_front.sv =====
module stt_front
	import stt_pkg::*;
#(
	parameter int LINE_BITS = LINE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] text_byte,
	input  logic       final_byte,
	input  logic       space,
	output logic       wr_en,
	output bundle_t    wr_data
);

	localparam int KW_N = 6;
	localparam logic [KW_N-1:0] KW_ALL = {KW_N{1'b1}};
	localparam logic [7:0] KW_TEXT [KW_N][8] = '{
		'{"r", "e", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"f", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"v", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"f", "a", "l", "s", "e", 8'h00, 8'h00, 8'h00},
		'{"n", "u", "l", "l", 8'h00, 8'h00, 8'h00, 8'h00}
	};
	localparam logic [2:0] KW_LEN [KW_N] = '{3'd3, 3'd2, 3'd3, 3'd4, 3'd5, 3'd4};

	function automatic logic [KW_N-1:0] kw_filter(input logic [KW_N-1:0] cand,
			input logic [2:0] len, input logic [7:0] c);
		logic [KW_N-1:0] r;
		r = cand;
		for (int k = 0; k < KW_N; k++) begin
			if (len >= KW_LEN[k] || KW_TEXT[k][len] != c)
				r[k] = 1'b0;
		end
		return r;
	endfunction

	function automatic logic [2:0] len_inc(input logic [2:0] len);
		return (len == 3'd7) ? len : len + 3'd1;
	endfunction

	function automatic logic [4:0] ident_class(input logic [KW_N-1:0] cand,
			input logic [2:0] len);
		logic [4:0] r;
		r = CLS_IDENT;
		for (int k = KW_N - 1; k >= 0; k--) begin
			if (cand[k] && KW_LEN[k] == len)
				r = CLS_KW_BASE + 5'(k);
		end
		return r;
	endfunction

	function automatic logic [4:0] open_class(input mode_t mode, input logic dot,
			input logic [KW_N-1:0] cand, input logic [2:0] len);
		logic [4:0] r;
		unique case (mode)
			MODE_IDENT: r = ident_class(cand, len);
			MODE_NUM:   r = dot ? CLS_FLOAT : CLS_INT;
			default:    r = CLS_STRING;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] op_class(input logic [7:0] c);
		logic [4:0] r;
		case (c)
			"(":     r = CLS_OP_BASE;
			")":     r = CLS_OP_BASE + 5'd1;
			"[":     r = CLS_OP_BASE + 5'd2;
			"]":     r = CLS_OP_BASE + 5'd3;
			"{":     r = CLS_OP_BASE + 5'd4;
			"}":     r = CLS_OP_BASE + 5'd5;
			"+":     r = CLS_OP_BASE + 5'd6;
			"-":     r = CLS_OP_BASE + 5'd7;
			"*":     r = CLS_OP_BASE + 5'd8;
			"/":     r = CLS_OP_BASE + 5'd9;
			"=":     r = CLS_OP_BASE + 5'd10;
			";":     r = CLS_OP_BASE + 5'd11;
			".":     r = CLS_OP_BASE + 5'd12;
			":":     r = CLS_OP_BASE + 5'd13;
			default: r = CLS_UNKNOWN;
		endcase
		return r;
	endfunction

	function automatic event_t mk_ev(input logic [1:0] kind, input logic [4:0] cls,
			input logic [7:0] chr, input logic [LINE_OUT_W-1:0] line,
			input logic [1:0] err);
		event_t e;
		e.kind = kind;
		e.cls  = cls;
		e.chr  = chr;
		e.line = line;
		e.err  = err;
		return e;
	endfunction

	mode_t                 mode_q, mode_n, mid_mode;
	logic                  dot_q, dot_n, mid_dot;
	logic [KW_N-1:0]       cand_q, cand_n, mid_cand;
	logic [2:0]            len_q, len_n, mid_len;
	logic [LINE_BITS-1:0]  line_q, line_n;
	logic                  bump;

	logic                  accept, fin;
	logic [7:0]            c;
	logic                  alpha, digit, under, dotc, quote, nl, sep;
	logic                  cont_ident, cont_num, str_close, str_keep, ends_token;
	logic                  done, go_idle, held;
	logic [1:0]            herr;
	logic [LINE_OUT_W-1:0] line_old, line_new;

	event_t [EV_SLOTS-1:0] ev;
	logic [CNT_W-1:0]      n;

	assign c        = text_byte;
	assign fin      = final_byte;
	assign in_ready = space;
	assign accept   = in_valid && space;
	assign line_old = LINE_OUT_W'(line_q);
	assign line_new = LINE_OUT_W'(line_n);

	always_comb begin
		alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
		digit = c >= "0" && c <= "9";
		under = c == "_";
		dotc  = c == ".";
		quote = c == "\"";
		nl    = c == "\n";
		sep   = c == " " || c == "\t";

		cont_ident = mode_q == MODE_IDENT && (alpha || digit || under);
		cont_num   = mode_q == MODE_NUM && (digit || dotc);
		str_close  = mode_q == MODE_STR && quote;
		str_keep   = mode_q == MODE_STR && !quote;
		ends_token = (mode_q == MODE_IDENT && !cont_ident) ||
		             (mode_q == MODE_NUM && !cont_num);
		done       = cont_ident || cont_num || str_keep;
		go_idle    = !done && !str_close;
		held       = fin && (done || (go_idle && (alpha || under || digit)));
		herr       = (str_keep && nl) ? ERR_NL : ERR_NONE;
	end

	// state after this byte, before the end-of-text clear
	always_comb begin
		mid_mode = mode_q;
		mid_dot  = dot_q;
		mid_cand = cand_q;
		mid_len  = len_q;
		bump     = 1'b0;
		if (cont_ident) begin
			mid_cand = kw_filter(cand_q, len_q, c);
			mid_len  = len_inc(len_q);
		end
		if (cont_num && dotc)
			mid_dot = 1'b1;
		if (ends_token || str_close) begin
			mid_mode = MODE_IDLE;
			mid_dot  = 1'b0;
			mid_cand = KW_ALL;
			mid_len  = 3'd0;
		end
		if (go_idle) begin
			if (sep) begin
				mid_mode = mid_mode;
			end else if (nl) begin
				bump = 1'b1;
			end else if (alpha || under) begin
				mid_mode = MODE_IDENT;
				mid_dot  = 1'b0;
				mid_cand = kw_filter(KW_ALL, 3'd0, c);
				mid_len  = 3'd1;
			end else if (digit) begin
				mid_mode = MODE_NUM;
				mid_dot  = 1'b0;
				mid_cand = KW_ALL;
				mid_len  = 3'd0;
			end else if (quote) begin
				mid_mode = MODE_STR;
				mid_dot  = 1'b0;
				mid_cand = KW_ALL;
				mid_len  = 3'd0;
			end
		end
		line_n = bump ? line_q + LINE_BITS'(1) : line_q;
		if (fin) begin
			mode_n = MODE_IDLE;
			dot_n  = 1'b0;
			cand_n = KW_ALL;
			len_n  = 3'd0;
		end else begin
			mode_n = mid_mode;
			dot_n  = mid_dot;
			cand_n = mid_cand;
			len_n  = mid_len;
		end
	end

	always_comb begin
		logic [4:0] cc;
		logic [4:0] oc;
		ev = '0;
		n  = '0;
		cc = (mode_q == MODE_IDENT) ? CLS_IDENT :
		     (mode_q == MODE_NUM) ? (mid_dot ? CLS_FLOAT : CLS_INT) : CLS_STRING;
		oc = op_class(c);
		if (ends_token) begin
			ev[n] = mk_ev(EV_DONE, open_class(mode_q, dot_q, cand_q, len_q), 8'h00,
			              line_old, ERR_NONE);
			n = n + CNT_W'(1);
		end
		if (str_close) begin
			ev[n] = mk_ev(EV_DONE, CLS_STRING, 8'h00, line_old, ERR_NONE);
			n = n + CNT_W'(1);
		end
		if (done && !fin) begin
			ev[n] = mk_ev(EV_CHAR, cc, c, line_old, herr);
			n = n + CNT_W'(1);
		end
		if (go_idle && !sep && !nl && !quote) begin
			if (alpha || under) begin
				if (!fin) begin
					ev[n] = mk_ev(EV_CHAR, CLS_IDENT, c, line_old, ERR_NONE);
					n = n + CNT_W'(1);
				end
			end else if (digit) begin
				if (!fin) begin
					ev[n] = mk_ev(EV_CHAR, CLS_INT, c, line_old, ERR_NONE);
					n = n + CNT_W'(1);
				end
			end else begin
				ev[n] = mk_ev(EV_DONE, oc, c, line_old,
				              (oc == CLS_UNKNOWN) ? ERR_UNKNOWN : ERR_NONE);
				n = n + CNT_W'(1);
			end
		end
		if (fin) begin
			if (!str_close && mid_mode != MODE_IDLE) begin
				ev[n] = mk_ev(EV_DONE, open_class(mid_mode, mid_dot, mid_cand, mid_len),
				              held ? c : 8'h00, line_old, held ? herr : ERR_NONE);
				n = n + CNT_W'(1);
			end
			ev[n] = mk_ev(EV_EOF, CLS_EOF, 8'h00, line_new, ERR_NONE);
			n = n + CNT_W'(1);
		end
	end

	assign wr_en       = accept && (n != '0);
	assign wr_data.cnt = n;
	assign wr_data.ev  = ev;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			dot_q  <= 1'b0;
			cand_q <= KW_ALL;
			len_q  <= 3'd0;
			line_q <= LINE_BITS'(1);
		end else if (accept) begin
			mode_q <= mode_n;
			dot_q  <= dot_n;
			cand_q <= cand_n;
			len_q  <= len_n;
			line_q <= line_n;
		end
	end

endmodule

// ===== sv/stt_queue.sv =====
module stt_queue
	import stt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_en,
	input  bundle_t wr_data,
	output logic    space,
	input  logic    rd_en,
	output logic    head_valid,
	output bundle_t head
);

	bundle_t               mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wptr_q, rptr_q;
	logic [QUEUE_AW:0]     cnt_q;

	assign space      = cnt_q != (QUEUE_AW + 1)'(QUEUE_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr_en)
				wptr_q <= wptr_q + QUEUE_AW'(1);
			if (rd_en)
				rptr_q <= rptr_q + QUEUE_AW'(1);
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + (QUEUE_AW + 1)'(1);
				2'b01:   cnt_q <= cnt_q - (QUEUE_AW + 1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== sv/stt_back.sv =====
module stt_back
	import stt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  bundle_t               head,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            event_kind,
	output logic [4:0]            token_class,
	output logic [7:0]            char_value,
	output logic [LINE_OUT_W-1:0] line_count,
	output logic [1:0]            error_code,
	output logic                  run_last
);

	logic [CNT_W-1:0] idx_q;
	logic             out_valid_q;
	logic             load, last;
	event_t           cur;

	assign load = head_valid && (!out_valid_q || out_ready);
	assign cur  = head.ev[idx_q];
	assign last = (idx_q + CNT_W'(1)) == head.cnt;
	assign pop  = load && last;

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			idx_q       <= last ? '0 : idx_q + CNT_W'(1);
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			event_kind  <= cur.kind;
			token_class <= cur.cls;
			char_value  <= cur.chr;
			line_count  <= cur.line;
			error_code  <= cur.err;
			run_last    <= last;
		end
	end

endmodule

// ===== test/tb_source_text_tokenizer_top.sv =====
`timescale 1ns / 100ps

module tb_source_text_tokenizer_top
	import stt_pkg::*;
();

	localparam int STALL_LIMIT = 4000;
	localparam int RANDOM_BYTES = 380;

	typedef struct packed {
		logic [1:0]            kind;
		logic [4:0]            cls;
		logic [7:0]            chr;
		logic [LINE_OUT_W-1:0] line;
		logic [1:0]            err;
		logic                  last;
	} tok_event_t;

	typedef struct {
		logic [7:0] ch;
		logic       fin;
		logic       pause;
	} src_byte_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [7:0]            text_byte = 8'd0;
	logic                  final_byte = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [1:0]            event_kind;
	logic [4:0]            token_class;
	logic [7:0]            char_value;
	logic [LINE_OUT_W-1:0] line_count;
	logic [1:0]            error_code;
	logic                  run_last;

	source_text_tokenizer_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.text_byte  (text_byte),
		.final_byte (final_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.event_kind (event_kind),
		.token_class(token_class),
		.char_value (char_value),
		.line_count (line_count),
		.error_code (error_code),
		.run_last   (run_last)
	);

	string kw_text [6] = '{"ret", "fn", "var", "true", "false", "null"};
	string op_chars = "()[]{}+-*/=;.:";

	// lexer shadow state
	mode_t                 lex_state;
	logic                  frac_seen;
	logic [5:0]            kw_alive;
	logic [2:0]            word_len;
	logic [LINE_OUT_W-1:0] cur_line;
	tok_event_t            step_ev [3];
	int                    step_n;

	tok_event_t  expected_events [$];
	src_byte_t   pending_items [$];
	logic [7:0]  text_buf [$];

	int total_items;
	int bytes_accepted;
	int results_seen;
	int mismatch_count;
	int stall_cycles;
	int send_idle_pct;
	int recv_idle_pct;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic void reset_token();
		lex_state = MODE_IDLE;
		frac_seen = 1'b0;
		kw_alive = 6'h3F;
		word_len = 3'd0;
	endfunction

	function automatic void extend_word(input logic [7:0] c);
		for (int k = 0; k < 6; k++)
			if (word_len >= kw_text[k].len() || kw_text[k][word_len] != c)
				kw_alive[k] = 1'b0;
		if (word_len < 3'd7)
			word_len++;
	endfunction

	function automatic logic [4:0] current_class();
		if (lex_state == MODE_IDENT) begin
			for (int k = 0; k < 6; k++)
				if (kw_alive[k] && kw_text[k].len() == word_len)
					return CLS_KW_BASE + 5'(k);
			return CLS_IDENT;
		end
		if (lex_state == MODE_NUM)
			return frac_seen ? CLS_FLOAT : CLS_INT;
		return CLS_STRING;
	endfunction

	function automatic void stage_event(input logic [1:0] kind, input logic [4:0] cls,
			input logic [7:0] chr, input logic [1:0] err);
		step_ev[step_n].kind = kind;
		step_ev[step_n].cls = cls;
		step_ev[step_n].chr = chr;
		step_ev[step_n].line = cur_line;
		step_ev[step_n].err = err;
		step_ev[step_n].last = 1'b0;
		step_n++;
	endfunction

	task automatic predict_byte(input logic [7:0] c, input logic fin);
		bit         extend;
		bit         held;
		bit         closed;
		logic [1:0] held_err;
		logic [4:0] op_cls;
		tok_event_t ev;
		extend = 1'b0;
		held = 1'b0;
		closed = 1'b0;
		held_err = ERR_NONE;
		step_n = 0;
		case (lex_state)
		MODE_IDENT: begin
			if (is_letter(c) || is_digit(c) || c == "_") begin
				extend_word(c);
				extend = 1'b1;
			end else begin
				stage_event(EV_DONE, current_class(), 8'd0, ERR_NONE);
				reset_token();
			end
		end
		MODE_NUM: begin
			if (is_digit(c) || c == ".") begin
				if (c == ".")
					frac_seen = 1'b1;
				extend = 1'b1;
			end else begin
				stage_event(EV_DONE, current_class(), 8'd0, ERR_NONE);
				reset_token();
			end
		end
		MODE_STR: begin
			if (c == "\"") begin
				stage_event(EV_DONE, CLS_STRING, 8'd0, ERR_NONE);
				reset_token();
				closed = 1'b1;
			end else begin
				held_err = (c == "\n") ? ERR_NL : ERR_NONE;
				extend = 1'b1;
			end
		end
		default: ;
		endcase

		if (closed) begin
		end else if (extend) begin
			if (fin)
				held = 1'b1;
			else
				stage_event(EV_CHAR, (current_class() > CLS_STRING) ? CLS_IDENT : current_class(),
					c, held_err);
		end else if (c == " " || c == "\t") begin
		end else if (c == "\n") begin
			cur_line++;
		end else if (is_letter(c) || c == "_") begin
			reset_token();
			lex_state = MODE_IDENT;
			extend_word(c);
			if (fin)
				held = 1'b1;
			else
				stage_event(EV_CHAR, CLS_IDENT, c, ERR_NONE);
		end else if (is_digit(c)) begin
			reset_token();
			lex_state = MODE_NUM;
			if (fin)
				held = 1'b1;
			else
				stage_event(EV_CHAR, CLS_INT, c, ERR_NONE);
		end else if (c == "\"") begin
			reset_token();
			lex_state = MODE_STR;
		end else begin
			op_cls = CLS_UNKNOWN;
			for (int k = 0; k < 14; k++)
				if (op_chars[k] == c)
					op_cls = CLS_OP_BASE + 5'(k);
			stage_event(EV_DONE, op_cls, c, (op_cls == CLS_UNKNOWN) ? ERR_UNKNOWN : ERR_NONE);
		end

		if (fin) begin
			if (lex_state != MODE_IDLE)
				stage_event(EV_DONE, current_class(), held ? c : 8'd0, held ? held_err : ERR_NONE);
			stage_event(EV_EOF, CLS_EOF, 8'd0, ERR_NONE);
			reset_token();
		end

		for (int i = 0; i < step_n; i++) begin
			ev = step_ev[i];
			ev.last = (i == step_n - 1);
			expected_events.insert(expected_events.size(), ev);
		end
	endtask

	task automatic report_error(input string what);
		mismatch_count++;
		$display("%0t ERROR: %s", $time, what);
	endtask

	function automatic void add_char(input logic [7:0] ch);
		text_buf.insert(text_buf.size(), ch);
	endfunction

	task automatic add_string(input string s);
		for (int i = 0; i < s.len(); i++)
			add_char(s[i]);
	endtask

	task automatic flush_text(input bit pause);
		src_byte_t item;
		for (int i = 0; i < text_buf.size(); i++) begin
			item.ch = text_buf[i];
			item.fin = (i == text_buf.size() - 1);
			item.pause = pause && (i == 0);
			pending_items.insert(pending_items.size(), item);
		end
		text_buf.delete();
	endtask

	function automatic logic [7:0] word_char();
		case ($urandom_range(3))
		0: return 8'("a" + $urandom_range(25));
		1: return 8'("A" + $urandom_range(25));
		2: return 8'("0" + $urandom_range(9));
		default: return "_";
		endcase
	endfunction

	task automatic add_token();
		string      word;
		int         len;
		logic [7:0] ch;
		case ($urandom_range(10))
		0, 1: begin
			word = kw_text[$urandom_range(5)];
			case ($urandom_range(3))
			0: begin
				add_string(word);
				add_char(word_char());
			end
			1: add_string(word.substr(0, word.len() - 2));
			default: add_string(word);
			endcase
		end
		2, 3: begin
			len = ($urandom_range(6) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 5);
			add_char($urandom_range(4) == 0 ? 8'("_") : 8'("a" + $urandom_range(25)));
			for (int i = 1; i < len; i++)
				add_char(word_char());
		end
		4: begin
			len = $urandom_range(1, 6);
			for (int i = 0; i < len; i++)
				add_char(8'("0" + $urandom_range(9)));
		end
		5: begin
			len = $urandom_range(1, 3);
			for (int i = 0; i < len; i++)
				add_char(8'("0" + $urandom_range(9)));
			add_char(".");
			len = $urandom_range(0, 3);
			for (int i = 0; i < len; i++)
				add_char($urandom_range(5) == 0 ? 8'(".") : 8'("0" + $urandom_range(9)));
		end
		6: begin
			add_char("\"");
			len = $urandom_range(0, 8);
			for (int i = 0; i < len; i++) begin
				ch = ($urandom_range(7) == 0) ? 8'("\n") : 8'($urandom_range(32, 126));
				add_char(ch == "\"" ? 8'("q") : ch);
			end
			if ($urandom_range(7) != 0)
				add_char("\"");
		end
		7, 8: add_char(op_chars[$urandom_range(13)]);
		9: add_char(8'($urandom_range(255)));
		default: add_char("\n");
		endcase
		case ($urandom_range(5))
		2, 3: add_char(" ");
		4: add_char("\t");
		5: add_char("\n");
		default: ;
		endcase
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			text_byte <= 8'd0;
			final_byte <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				predict_byte(text_byte, final_byte);
				bytes_accepted++;
			end
			if (bytes_accepted < total_items / 3) begin
				send_idle_pct = 20;
				recv_idle_pct = 86;
			end else if (bytes_accepted < 2 * total_items / 3) begin
				send_idle_pct = 86;
				recv_idle_pct = 20;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (!in_valid || in_ready) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct
						&& !(pending_items[0].pause && expected_events.size() > 0)) begin
					in_valid <= 1'b1;
					text_byte <= pending_items[0].ch;
					final_byte <= pending_items[0].fin;
					void'(pending_items.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		tok_event_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_events.size() == 0) begin
					report_error($sformatf("result %0d arrived with nothing expected", results_seen));
				end else begin
					want = expected_events.pop_front();
					if (event_kind !== want.kind)
						report_error($sformatf("result %0d event_kind %0d, want %0d",
							results_seen, event_kind, want.kind));
					if (token_class !== want.cls)
						report_error($sformatf("result %0d token_class %0d, want %0d",
							results_seen, token_class, want.cls));
					if (char_value !== want.chr)
						report_error($sformatf("result %0d char_value %02h, want %02h",
							results_seen, char_value, want.chr));
					if (line_count !== want.line)
						report_error($sformatf("result %0d line_count %0d, want %0d",
							results_seen, line_count, want.line));
					if (error_code !== want.err)
						report_error($sformatf("result %0d error_code %0d, want %0d",
							results_seen, error_code, want.err));
					if (run_last !== want.last)
						report_error($sformatf("result %0d run_last %0b, want %0b",
							results_seen, run_last, want.last));
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t ERROR: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		int texts;
		reset_token();
		cur_line = 1;
		bytes_accepted = 0;
		results_seen = 0;
		mismatch_count = 0;
		stall_cycles = 0;
		send_idle_pct = 20;
		recv_idle_pct = 86;

		add_string("ret fn:9.1.2\"a\n\"_x\t~");
		add_char(8'hFF);
		add_string("\nfalse");
		flush_text(1'b0);
		add_char(8'h80);
		add_char("\"");
		flush_text(1'b0);

		texts = 0;
		while (pending_items.size() < RANDOM_BYTES) begin
			for (int i = $urandom_range(1, 12); i > 0; i--)
				add_token();
			flush_text(texts % 5 == 2);
			texts++;
		end
		total_items = pending_items.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (!(bytes_accepted == total_items && expected_events.size() == 0))
			@(posedge clk);
		repeat (16) @(posedge clk);

		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
